FILE: src/cll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor linked list package
// Sizes, request codes, pointer helpers and the command and status words
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam int unsigned POOL_NODES = 64;
  localparam int unsigned IDX_W      = $clog2(POOL_NODES + 1);
  localparam int unsigned ADDR_W     = $clog2(POOL_NODES);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned TYPE_W     = 3;
  localparam int unsigned COUNT_W    = 7;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam idx_t NIL_IDX = idx_t'(POOL_NODES);

  localparam logic [TYPE_W-1:0] REQ_INIT   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_HEAD   = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_NEXT   = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_QUERY  = 3'd6;

  typedef struct packed {
    logic accept;
    logic decode;
    logic clear;
    logic take;
    logic wr_node;
    logic commit;
    logic del;
    logic move;
    logic capture;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req;
    logic              err;
    logic              nx_node;
  } status_t;

  function automatic logic is_node(idx_t p);
    return p < idx_t'(POOL_NODES);
  endfunction

  function automatic addr_t addr_of(idx_t p);
    return p[ADDR_W-1:0];
  endfunction

endpackage

FILE: src/cll_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor linked list channels
// Request and response handshake interfaces with valid, ready and payload.
// ----------------------------------------------------------------------------
interface cll_req_if;
  logic                                valid;
  logic                                ready;
  logic [cll_pkg::TYPE_W-1:0]          req_type;
  logic signed [cll_pkg::DATA_W-1:0]   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface cll_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                error;
  logic                                cursor_valid;
  logic signed [cll_pkg::DATA_W-1:0]   cursor_data;
  logic                                at_head;
  logic                                at_rear;
  logic [cll_pkg::COUNT_W-1:0]         node_count;

  modport source (output valid, output error, output cursor_valid, output cursor_data,
                  output at_head, output at_rear, output node_count, input ready);
  modport sink   (input valid, input error, input cursor_valid, input cursor_data,
                  input at_head, input at_rear, input node_count, output ready);
endinterface

FILE: src/cll_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor linked list datapath
// Node value and link memories, free node stack, list pointers, cursor node
// cache and the response register, all driven by controller commands.
// ----------------------------------------------------------------------------
module cll_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cll_pkg::cmd_t                     cmd_i,
  output cll_pkg::status_t                  st_o,
  input  logic [cll_pkg::TYPE_W-1:0]        in_type_i,
  input  logic signed [cll_pkg::DATA_W-1:0] in_value_i,
  output logic                              error_o,
  output logic                              cursor_valid_o,
  output logic signed [cll_pkg::DATA_W-1:0] cursor_data_o,
  output logic                              at_head_o,
  output logic                              at_rear_o,
  output logic [cll_pkg::COUNT_W-1:0]       node_count_o
);

  logic signed [cll_pkg::DATA_W-1:0] val_mem  [cll_pkg::POOL_NODES];
  cll_pkg::idx_t                     link_mem [cll_pkg::POOL_NODES];
  cll_pkg::addr_t                    stk_mem  [cll_pkg::POOL_NODES];

  logic [cll_pkg::TYPE_W-1:0]        req_q;
  logic signed [cll_pkg::DATA_W-1:0] data_q;
  logic signed [cll_pkg::DATA_W-1:0] cval_q;
  cll_pkg::idx_t                     clink_q;
  logic signed [cll_pkg::DATA_W-1:0] val_rd_q;
  cll_pkg::idx_t                     link_rd_q;
  cll_pkg::addr_t                    stk_rd_q;
  cll_pkg::idx_t                     head_q, cur_q, prev_q, new_q;
  cll_pkg::idx_t                     count_q, fresh_q, sp_q;
  logic                              list_q, err_q;

  logic          err_c, full_c, cur_node_c, nx_node_c, cur_head_c, prev_node_c;
  logic          cvalid_c;
  logic          link_we;
  cll_pkg::idx_t link_addr, link_wdata, sp_dec;

  assign full_c      = count_q >= cll_pkg::idx_t'(cll_pkg::POOL_NODES);
  assign cur_node_c  = cll_pkg::is_node(cur_q);
  assign nx_node_c   = cll_pkg::is_node(clink_q);
  assign prev_node_c = cll_pkg::is_node(prev_q);
  assign cur_head_c  = cur_q == head_q;
  assign sp_dec      = sp_q - 1'b1;
  assign cvalid_c    = list_q && cur_node_c;

  always_comb begin
    case (req_q)
      cll_pkg::REQ_INIT:   err_c = 1'b0;
      cll_pkg::REQ_INSERT: err_c = !list_q || full_c;
      cll_pkg::REQ_APPEND: err_c = !list_q || !cur_node_c || full_c;
      cll_pkg::REQ_DELETE: err_c = !list_q || !cur_node_c || (cur_head_c && !nx_node_c);
      cll_pkg::REQ_HEAD:   err_c = !list_q;
      cll_pkg::REQ_NEXT:   err_c = !list_q || !cur_node_c || !nx_node_c;
      cll_pkg::REQ_QUERY:  err_c = !list_q;
      default:             err_c = 1'b1;
    endcase
  end

  assign st_o.req     = req_q;
  assign st_o.err     = err_c;
  assign st_o.nx_node = nx_node_c;

  always_comb begin
    link_we    = 1'b0;
    link_addr  = new_q;
    link_wdata = cll_pkg::NIL_IDX;
    if (cmd_i.wr_node) begin
      link_we = 1'b1;
      if (req_q == cll_pkg::REQ_INSERT) begin
        link_wdata = cur_q;
      end else if (req_q == cll_pkg::REQ_APPEND) begin
        link_wdata = clink_q;
      end
    end else if (cmd_i.commit) begin
      link_wdata = new_q;
      if (req_q == cll_pkg::REQ_APPEND) begin
        link_we   = 1'b1;
        link_addr = cur_q;
      end else if (req_q == cll_pkg::REQ_INSERT) begin
        link_we   = !cur_head_c && prev_node_c;
        link_addr = prev_q;
      end
    end else if (cmd_i.del) begin
      link_we    = !cur_head_c && prev_node_c;
      link_addr  = prev_q;
      link_wdata = clink_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_node) begin
      val_mem[cll_pkg::addr_of(new_q)] <= data_q;
    end
    if (link_we) begin
      link_mem[cll_pkg::addr_of(link_addr)] <= link_wdata;
    end
    if (cmd_i.del) begin
      stk_mem[cll_pkg::addr_of(sp_q)] <= cll_pkg::addr_of(cur_q);
    end
    val_rd_q  <= val_mem[cll_pkg::addr_of(cur_q)];
    link_rd_q <= link_mem[cll_pkg::addr_of(cur_q)];
    stk_rd_q  <= stk_mem[cll_pkg::addr_of(sp_dec)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= cll_pkg::NIL_IDX;
      cur_q   <= cll_pkg::NIL_IDX;
      prev_q  <= cll_pkg::NIL_IDX;
      new_q   <= cll_pkg::NIL_IDX;
      count_q <= '0;
      fresh_q <= '0;
      sp_q    <= '0;
      list_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      if (cmd_i.decode) begin
        err_q <= err_c;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        fresh_q <= '0;
        sp_q    <= '0;
      end
      if (cmd_i.take) begin
        count_q <= count_q + 1'b1;
        if (sp_q != '0) begin
          new_q <= cll_pkg::idx_t'(stk_rd_q);
          sp_q  <= sp_dec;
        end else begin
          new_q   <= fresh_q;
          fresh_q <= fresh_q + 1'b1;
        end
      end
      if (cmd_i.commit) begin
        case (req_q)
          cll_pkg::REQ_INIT: begin
            head_q <= new_q;
            cur_q  <= new_q;
            prev_q <= cll_pkg::NIL_IDX;
            list_q <= 1'b1;
          end
          cll_pkg::REQ_INSERT: begin
            cur_q <= new_q;
            if (cur_head_c) begin
              head_q <= new_q;
            end
          end
          cll_pkg::REQ_APPEND: begin
            prev_q <= cur_q;
            cur_q  <= new_q;
          end
          default: ;
        endcase
      end
      if (cmd_i.del) begin
        if (cur_head_c) begin
          head_q <= clink_q;
        end
        cur_q   <= clink_q;
        sp_q    <= sp_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.move) begin
        if (req_q == cll_pkg::REQ_HEAD) begin
          cur_q  <= head_q;
          prev_q <= cll_pkg::NIL_IDX;
        end else begin
          prev_q <= cur_q;
          cur_q  <= clink_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q  <= in_type_i;
      data_q <= in_value_i;
    end
    if (cmd_i.commit) begin
      cval_q <= data_q;
      if (req_q == cll_pkg::REQ_INSERT) begin
        clink_q <= cur_q;
      end else if (req_q != cll_pkg::REQ_APPEND) begin
        clink_q <= cll_pkg::NIL_IDX;
      end
    end
    if (cmd_i.capture) begin
      cval_q  <= val_rd_q;
      clink_q <= link_rd_q;
    end
    if (cmd_i.load_out) begin
      error_o        <= err_q;
      cursor_valid_o <= cvalid_c;
      cursor_data_o  <= cvalid_c ? cval_q : '0;
      at_head_o      <= !prev_node_c;
      at_rear_o      <= !cvalid_c || !nx_node_c;
      node_count_o   <= cll_pkg::COUNT_W'(count_q);
    end
  end

endmodule

FILE: src/cll_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor linked list controller
// Sequences each request through decode, node allocation, memory writes,
// cursor reload and the response handshake.
// ----------------------------------------------------------------------------
module cll_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cll_pkg::status_t st_i,
  output cll_pkg::cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECODE = 8'b0000_0010,
    ST_TAKE   = 8'b0000_0100,
    ST_WNODE  = 8'b0000_1000,
    ST_COMMIT = 8'b0001_0000,
    ST_RD     = 8'b0010_0000,
    ST_CAP    = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (st_i.err || st_i.req == cll_pkg::REQ_QUERY) begin
          state_d = ST_FIN;
        end else if (st_i.req == cll_pkg::REQ_INIT) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_TAKE;
        end else if (st_i.req == cll_pkg::REQ_INSERT || st_i.req == cll_pkg::REQ_APPEND) begin
          state_d = ST_TAKE;
        end else if (st_i.req == cll_pkg::REQ_DELETE) begin
          cmd_o.del = 1'b1;
          state_d   = st_i.nx_node ? ST_RD : ST_FIN;
        end else begin
          cmd_o.move = 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_TAKE: begin
        cmd_o.take = 1'b1;
        state_d    = ST_WNODE;
      end
      ST_WNODE: begin
        cmd_o.wr_node = 1'b1;
        state_d       = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_FIN;
      end
      ST_RD: begin
        state_d = ST_CAP;
      end
      ST_CAP: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/cursor_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor linked list engine
// Singly linked list of signed 32-bit values in a fixed node pool with head,
// cursor and previous pointers.
// ----------------------------------------------------------------------------
// Requests arrive on req_i as a word of req_type and value; every request
// yields exactly one response word on rsp_o with the error flag, the cursor
// state and the node count after the request.
// One request is worked on at a time. Query, refused requests and delete at
// the tail pass from decode straight to the response; delete, go head and
// go next add a registered memory read and a capture of the new cursor node;
// init, insert and append take a node, write it and then commit the pointers.
// The node memory write port and the registered cursor reload set these steps.
// A new request is accepted once the previous response is loaded,
// even while that response still waits on rsp_o.
// A stalled receiver holds the response stable; the engine then finishes
// the next request and waits until the response register is free.
// Reset leaves no list, so every request except init is refused. Freed nodes
// go on a free stack and untouched nodes are handed out by a fill count, so
// reset and init need no clearing pass over the memories.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  cll_req_if.sink   req_i,
  cll_rsp_if.source rsp_o
);

  cll_pkg::cmd_t    cmd;
  cll_pkg::status_t st;

  cll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  cll_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .in_type_i      (req_i.req_type),
    .in_value_i     (req_i.value),
    .error_o        (rsp_o.error),
    .cursor_valid_o (rsp_o.cursor_valid),
    .cursor_data_o  (rsp_o.cursor_data),
    .at_head_o      (rsp_o.at_head),
    .at_rear_o      (rsp_o.at_rear),
    .node_count_o   (rsp_o.node_count)
  );

endmodule

FILE: src/cll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor linked list checker
// Port level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module cll_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic                              cursor_valid_i,
  input logic signed [cll_pkg::DATA_W-1:0] cursor_data_i,
  input logic                              at_rear_i,
  input logic [cll_pkg::COUNT_W-1:0]       node_count_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(cursor_data_i))
    else $error("response word dropped or changed while stalled");

  a_no_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !cursor_valid_i |-> cursor_data_i == '0 && at_rear_i)
    else $error("cursor past end must read as zero data at the rear");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> node_count_i <= cll_pkg::COUNT_W'(cll_pkg::POOL_NODES))
    else $error("node count exceeds the pool size");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && cursor_valid_i |-> node_count_i != '0)
    else $error("cursor on a node while the list holds no nodes");

endmodule

bind cursor_linked_list_engine cll_checker u_cll_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .cursor_valid_i (rsp_o.cursor_valid),
  .cursor_data_i  (rsp_o.cursor_data),
  .at_rear_i      (rsp_o.at_rear),
  .node_count_i   (rsp_o.node_count)
);
